FILE: hw/rtl/mpsm_pkg.sv
// Shared constants, codes and controller/datapath types of the string matcher.
package mpsm_pkg;

  localparam int MAX_NODES    = 256;
  localparam int SYMBOL_BITS  = 8;
  localparam int MAX_WORD_LEN = 32;
  localparam int MAX_RESULTS  = 32;
  localparam int ALPHA        = 1 << SYMBOL_BITS;
  localparam int NODE_W       = $clog2(MAX_NODES);
  localparam int NCNT_W       = NODE_W + 1;
  localparam int DEPTH_W      = 6;
  localparam int COUNT_W      = 8;
  localparam int POS_W        = 32;
  localparam int NRES_W       = $clog2(MAX_RESULTS + 1);
  localparam int GOTO_AW      = NODE_W + SYMBOL_BITS;
  localparam int INFO_W       = 1 + COUNT_W + DEPTH_W;
  localparam int IN_W         = 16;
  localparam int OUT_W        = 88;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_END   = 3'd2;
  localparam logic [2:0] CMD_BUILD = 3'd3;
  localparam logic [2:0] CMD_START = 3'd4;
  localparam logic [2:0] CMD_SCAN  = 3'd5;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MATCH    = 3'd1,
    ST_NOMATCH  = 3'd2,
    ST_FULL     = 3'd3,
    ST_TOOLONG  = 3'd4,
    ST_NOTBUILT = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DEC, S_SWEEP, S_EMIT, S_ADD, S_END,
    S_B0_RD, S_B0, S_BQ, S_BQ_LD, S_BU_RD, S_BU, S_BF_LD, S_BF_RD, S_BF_CHK,
    S_SC_RD, S_SC_CHK, S_SC_FW, S_ST, S_ST_D, S_PUSH, S_POS
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_CLEAR, OP_SWEEP, OP_ADD_RD, OP_ADD_NEW, OP_ADD_OLD,
    OP_END_RD, OP_END_WR, OP_START, OP_B_INIT, OP_B0_RD, OP_B0, OP_BQ_RD, OP_BQ,
    OP_BU_RD, OP_NEXT_S, OP_BU, OP_BF_LD, OP_BF_RD, OP_BF_FRD, OP_BF_SET, OP_BUILT,
    OP_SC_INIT, OP_SC_RD, OP_SC_FRD, OP_SC_FW, OP_SC_SET, OP_ST_RD, OP_ST_WRV,
    OP_ST_STEP, OP_PUSH
  } op_e;

  typedef enum logic [1:0] {
    OPX_NONE, OPX_POS, OPX_EMIT
  } opx_e;

  typedef struct packed {
    op_e     op;
    opx_e    opx;
    status_e code;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       built;
    logic       depth_full;
    logic       table_full;
    logic       g_zero;
    logic       ins_zero;
    logic       sweep_last;
    logic       s_last;
    logic       q_more;
    logic       f_zero;
    logic       node_zero;
    logic       t_zero;
    logic       visited;
    logic       match;
    logic       cand_v;
    logic       out_full;
  } stat_t;

endpackage

FILE: hw/rtl/mpsm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module mpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mpsm_ctrl.sv
// Controller state machine of the string matcher: sequences the datapath operations.
module mpsm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mpsm_pkg::stat_t stat_i,
  output mpsm_pkg::ctrl_t ctrl_o
);

  mpsm_pkg::state_e  state_q, state_d;
  mpsm_pkg::status_e code_q, code_d;

  // State and pending result code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpsm_pkg::S_INIT;
      code_q  <= mpsm_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    case (state_q)
      mpsm_pkg::S_INIT: begin
        if (stat_i.sweep_last) state_d = mpsm_pkg::S_IDLE;
      end
      mpsm_pkg::S_IDLE: begin
        if (in_valid_i) state_d = mpsm_pkg::S_DEC;
      end
      mpsm_pkg::S_DEC: begin
        code_d  = mpsm_pkg::ST_OK;
        state_d = mpsm_pkg::S_EMIT;
        case (stat_i.cmd)
          mpsm_pkg::CMD_CLEAR: state_d = mpsm_pkg::S_SWEEP;
          mpsm_pkg::CMD_ADD: begin
            if (stat_i.depth_full) code_d = mpsm_pkg::ST_TOOLONG;
            else state_d = mpsm_pkg::S_ADD;
          end
          mpsm_pkg::CMD_END: begin
            if (!stat_i.ins_zero) state_d = mpsm_pkg::S_END;
          end
          mpsm_pkg::CMD_BUILD: state_d = mpsm_pkg::S_B0_RD;
          mpsm_pkg::CMD_SCAN: begin
            if (stat_i.built) state_d = mpsm_pkg::S_SC_RD;
            else code_d = mpsm_pkg::ST_NOTBUILT;
          end
          default: state_d = mpsm_pkg::S_EMIT;
        endcase
      end
      mpsm_pkg::S_SWEEP: begin
        code_d = mpsm_pkg::ST_OK;
        if (stat_i.sweep_last) state_d = mpsm_pkg::S_EMIT;
      end
      mpsm_pkg::S_ADD: begin
        if (stat_i.g_zero && stat_i.table_full) begin
          code_d  = mpsm_pkg::ST_FULL;
          state_d = mpsm_pkg::S_EMIT;
        end else if (stat_i.g_zero) begin
          state_d = mpsm_pkg::S_SWEEP;
        end else begin
          code_d  = mpsm_pkg::ST_OK;
          state_d = mpsm_pkg::S_EMIT;
        end
      end
      mpsm_pkg::S_END: begin
        code_d  = mpsm_pkg::ST_OK;
        state_d = mpsm_pkg::S_EMIT;
      end
      mpsm_pkg::S_B0_RD: state_d = mpsm_pkg::S_B0;
      mpsm_pkg::S_B0: begin
        state_d = stat_i.s_last ? mpsm_pkg::S_BQ : mpsm_pkg::S_B0_RD;
      end
      mpsm_pkg::S_BQ: begin
        if (stat_i.q_more) begin
          state_d = mpsm_pkg::S_BQ_LD;
        end else begin
          code_d  = mpsm_pkg::ST_OK;
          state_d = mpsm_pkg::S_EMIT;
        end
      end
      mpsm_pkg::S_BQ_LD: state_d = mpsm_pkg::S_BU_RD;
      mpsm_pkg::S_BU_RD: state_d = mpsm_pkg::S_BU;
      mpsm_pkg::S_BU: begin
        if (!stat_i.g_zero) state_d = mpsm_pkg::S_BF_LD;
        else state_d = stat_i.s_last ? mpsm_pkg::S_BQ : mpsm_pkg::S_BU_RD;
      end
      mpsm_pkg::S_BF_LD: state_d = mpsm_pkg::S_BF_RD;
      mpsm_pkg::S_BF_RD: state_d = mpsm_pkg::S_BF_CHK;
      mpsm_pkg::S_BF_CHK: begin
        if (stat_i.g_zero && !stat_i.f_zero) state_d = mpsm_pkg::S_BF_LD;
        else state_d = stat_i.s_last ? mpsm_pkg::S_BQ : mpsm_pkg::S_BU_RD;
      end
      mpsm_pkg::S_SC_RD: state_d = mpsm_pkg::S_SC_CHK;
      mpsm_pkg::S_SC_CHK: begin
        if (stat_i.g_zero && !stat_i.node_zero) state_d = mpsm_pkg::S_SC_FW;
        else state_d = mpsm_pkg::S_ST;
      end
      mpsm_pkg::S_SC_FW: state_d = mpsm_pkg::S_SC_RD;
      mpsm_pkg::S_ST: begin
        state_d = stat_i.t_zero ? mpsm_pkg::S_POS : mpsm_pkg::S_ST_D;
      end
      mpsm_pkg::S_ST_D: begin
        if (stat_i.visited) state_d = mpsm_pkg::S_POS;
        else if (stat_i.match && stat_i.cand_v) state_d = mpsm_pkg::S_PUSH;
        else state_d = mpsm_pkg::S_ST;
      end
      mpsm_pkg::S_PUSH: begin
        if (!stat_i.out_full) state_d = mpsm_pkg::S_ST;
      end
      mpsm_pkg::S_POS: begin
        code_d  = mpsm_pkg::ST_NOMATCH;
        state_d = mpsm_pkg::S_EMIT;
      end
      mpsm_pkg::S_EMIT: begin
        if (!stat_i.out_full) state_d = mpsm_pkg::S_IDLE;
      end
      default: state_d = mpsm_pkg::S_IDLE;
    endcase
  end

  // Operation issued to the datapath in each state.
  always_comb begin
    ctrl_o.op   = mpsm_pkg::OP_NONE;
    ctrl_o.opx  = mpsm_pkg::OPX_NONE;
    ctrl_o.code = code_q;
    in_ready_o  = 1'b0;
    case (state_q)
      mpsm_pkg::S_INIT: ctrl_o.op = mpsm_pkg::OP_SWEEP;
      mpsm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) ctrl_o.op = mpsm_pkg::OP_LATCH;
      end
      mpsm_pkg::S_DEC: begin
        case (stat_i.cmd)
          mpsm_pkg::CMD_CLEAR: ctrl_o.op = mpsm_pkg::OP_CLEAR;
          mpsm_pkg::CMD_ADD: begin
            if (!stat_i.depth_full) ctrl_o.op = mpsm_pkg::OP_ADD_RD;
          end
          mpsm_pkg::CMD_END: begin
            ctrl_o.op = stat_i.ins_zero ? mpsm_pkg::OP_END_WR : mpsm_pkg::OP_END_RD;
          end
          mpsm_pkg::CMD_BUILD: ctrl_o.op = mpsm_pkg::OP_B_INIT;
          mpsm_pkg::CMD_START: ctrl_o.op = mpsm_pkg::OP_START;
          mpsm_pkg::CMD_SCAN: begin
            if (stat_i.built) ctrl_o.op = mpsm_pkg::OP_SC_INIT;
          end
          default: ctrl_o.op = mpsm_pkg::OP_NONE;
        endcase
      end
      mpsm_pkg::S_SWEEP: ctrl_o.op = mpsm_pkg::OP_SWEEP;
      mpsm_pkg::S_ADD: begin
        if (!stat_i.g_zero) ctrl_o.op = mpsm_pkg::OP_ADD_OLD;
        else if (!stat_i.table_full) ctrl_o.op = mpsm_pkg::OP_ADD_NEW;
      end
      mpsm_pkg::S_END: ctrl_o.op = mpsm_pkg::OP_END_WR;
      mpsm_pkg::S_B0_RD: ctrl_o.op = mpsm_pkg::OP_B0_RD;
      mpsm_pkg::S_B0: ctrl_o.op = mpsm_pkg::OP_B0;
      mpsm_pkg::S_BQ: begin
        ctrl_o.op = stat_i.q_more ? mpsm_pkg::OP_BQ_RD : mpsm_pkg::OP_BUILT;
      end
      mpsm_pkg::S_BQ_LD: ctrl_o.op = mpsm_pkg::OP_BQ;
      mpsm_pkg::S_BU_RD: ctrl_o.op = mpsm_pkg::OP_BU_RD;
      mpsm_pkg::S_BU: begin
        ctrl_o.op = stat_i.g_zero ? mpsm_pkg::OP_NEXT_S : mpsm_pkg::OP_BU;
      end
      mpsm_pkg::S_BF_LD: ctrl_o.op = mpsm_pkg::OP_BF_LD;
      mpsm_pkg::S_BF_RD: ctrl_o.op = mpsm_pkg::OP_BF_RD;
      mpsm_pkg::S_BF_CHK: begin
        if (stat_i.g_zero && !stat_i.f_zero) ctrl_o.op = mpsm_pkg::OP_BF_FRD;
        else ctrl_o.op = mpsm_pkg::OP_BF_SET;
      end
      mpsm_pkg::S_SC_RD: ctrl_o.op = mpsm_pkg::OP_SC_RD;
      mpsm_pkg::S_SC_CHK: begin
        if (stat_i.g_zero && !stat_i.node_zero) ctrl_o.op = mpsm_pkg::OP_SC_FRD;
        else ctrl_o.op = mpsm_pkg::OP_SC_SET;
      end
      mpsm_pkg::S_SC_FW: ctrl_o.op = mpsm_pkg::OP_SC_FW;
      mpsm_pkg::S_ST: begin
        if (!stat_i.t_zero) ctrl_o.op = mpsm_pkg::OP_ST_RD;
      end
      mpsm_pkg::S_ST_D: begin
        if (!stat_i.visited) begin
          if (stat_i.match && stat_i.cand_v) ctrl_o.op = mpsm_pkg::OP_ST_WRV;
          else ctrl_o.op = mpsm_pkg::OP_ST_STEP;
        end
      end
      mpsm_pkg::S_PUSH: begin
        if (!stat_i.out_full) ctrl_o.op = mpsm_pkg::OP_PUSH;
      end
      mpsm_pkg::S_POS: ctrl_o.opx = mpsm_pkg::OPX_POS;
      mpsm_pkg::S_EMIT: begin
        if (!stat_i.out_full) ctrl_o.opx = mpsm_pkg::OPX_EMIT;
      end
      default: ctrl_o.op = mpsm_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: hw/rtl/mpsm_dp.sv
// Datapath of the string matcher: trie memories, walk registers and the result register.
module mpsm_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpsm_pkg::ctrl_t            ctrl_i,
  output mpsm_pkg::stat_t            stat_o,
  input  logic [mpsm_pkg::IN_W-1:0]  in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mpsm_pkg::OUT_W-1:0] out_data_o,
  output logic                       out_last_o
);

  localparam int NW = mpsm_pkg::NODE_W;
  localparam int SW = mpsm_pkg::SYMBOL_BITS;
  localparam int DW = mpsm_pkg::DEPTH_W;
  localparam int CW = mpsm_pkg::COUNT_W;
  localparam int PW = mpsm_pkg::POS_W;

  // Control registers.
  logic [2:0]                  cmd_q;
  logic [SW-1:0]               sym_q;
  logic [mpsm_pkg::NCNT_W-1:0] ntot_q, head_q, tail_q;
  logic [NW-1:0]               ins_q, scan_q, row_q, u_q, v_q, f_q, node_q, t_q;
  logic [DW-1:0]               ins_dep_q;
  logic [PW-1:0]               pos_q;
  logic                        built_q, cand_v_q, out_v_q;
  logic [SW-1:0]               cnt_q, s_q;
  logic [mpsm_pkg::NRES_W-1:0] nres_q;

  // Pending match and output register.
  logic [PW-1:0] cand_start_q, cand_end_q, out_start_q, out_end_q;
  logic [DW-1:0] cand_len_q, out_len_q;
  logic [CW-1:0] cand_cnt_q, out_cnt_q;
  mpsm_pkg::status_e out_st_q;
  logic          out_last_q;

  // Memory ports.
  logic                         g_we, g_re, f_we, f_re, i_we, i_re, q_we, q_re;
  logic [mpsm_pkg::GOTO_AW-1:0] g_waddr, g_raddr;
  logic [NW-1:0]                g_wdata, g_rdata, f_waddr, f_raddr, f_wdata, f_rdata;
  logic [NW-1:0]                i_waddr, i_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
  logic [mpsm_pkg::INFO_W-1:0]  i_wdata, i_rdata;

  logic [NW-1:0] new_node;
  logic          i_vis, match, tail_room, out_full, load_out;
  logic [CW-1:0] i_cnt;
  logic [DW-1:0] i_dep;
  logic [PW-1:0] new_start;

  assign new_node  = ntot_q[NW-1:0];
  assign i_vis     = i_rdata[mpsm_pkg::INFO_W-1];
  assign i_cnt     = i_rdata[DW +: CW];
  assign i_dep     = i_rdata[DW-1:0];
  assign match     = (i_cnt != '0) && (nres_q < mpsm_pkg::NRES_W'(mpsm_pkg::MAX_RESULTS));
  assign new_start = pos_q - PW'(i_dep) + PW'(1);
  assign tail_room = tail_q < mpsm_pkg::NCNT_W'(mpsm_pkg::MAX_NODES);
  assign out_full  = out_v_q && !out_ready_i;

  mpsm_ram #(.WIDTH(NW), .DEPTH(mpsm_pkg::MAX_NODES * mpsm_pkg::ALPHA)) u_goto (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .re_i(g_re), .raddr_i(g_raddr), .rdata_o(g_rdata)
  );
  mpsm_ram #(.WIDTH(NW), .DEPTH(mpsm_pkg::MAX_NODES)) u_fail (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .re_i(f_re), .raddr_i(f_raddr), .rdata_o(f_rdata)
  );
  mpsm_ram #(.WIDTH(mpsm_pkg::INFO_W), .DEPTH(mpsm_pkg::MAX_NODES)) u_info (
    .clk_i, .we_i(i_we), .waddr_i(i_waddr), .wdata_i(i_wdata),
    .re_i(i_re), .raddr_i(i_raddr), .rdata_o(i_rdata)
  );
  mpsm_ram #(.WIDTH(NW), .DEPTH(mpsm_pkg::MAX_NODES)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .re_i(q_re), .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  // Memory access for the current operation.
  always_comb begin
    g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_re = 1'b0; g_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;
    i_we = 1'b0; i_waddr = '0; i_wdata = '0; i_re = 1'b0; i_raddr = '0;
    q_we = 1'b0; q_waddr = tail_q[NW-1:0]; q_wdata = '0; q_re = 1'b0;
    q_raddr = head_q[NW-1:0];
    case (ctrl_i.op)
      mpsm_pkg::OP_SWEEP: begin
        g_we = 1'b1; g_waddr = {row_q, cnt_q};
      end
      mpsm_pkg::OP_ADD_RD: begin
        g_re = 1'b1; g_raddr = {ins_q, sym_q};
      end
      mpsm_pkg::OP_ADD_NEW: begin
        g_we = 1'b1; g_waddr = {ins_q, sym_q}; g_wdata = new_node;
        f_we = 1'b1; f_waddr = new_node;
        i_we = 1'b1; i_waddr = new_node;
        i_wdata = {1'b0, {CW{1'b0}}, ins_dep_q + DW'(1)};
      end
      mpsm_pkg::OP_END_RD: begin
        i_re = 1'b1; i_raddr = ins_q;
      end
      mpsm_pkg::OP_END_WR: begin
        i_we = (ins_q != '0); i_waddr = ins_q;
        i_wdata = {i_vis, (&i_cnt) ? i_cnt : i_cnt + CW'(1), i_dep};
      end
      mpsm_pkg::OP_B0_RD: begin
        g_re = 1'b1; g_raddr = {{NW{1'b0}}, s_q};
      end
      mpsm_pkg::OP_B0: begin
        f_we = (g_rdata != '0); f_waddr = g_rdata;
        q_we = (g_rdata != '0) && tail_room; q_wdata = g_rdata;
      end
      mpsm_pkg::OP_BQ_RD: q_re = 1'b1;
      mpsm_pkg::OP_BU_RD: begin
        g_re = 1'b1; g_raddr = {u_q, s_q};
      end
      mpsm_pkg::OP_BU: begin
        f_re = 1'b1; f_raddr = u_q;
      end
      mpsm_pkg::OP_BF_RD: begin
        g_re = 1'b1; g_raddr = {f_q, s_q};
      end
      mpsm_pkg::OP_BF_FRD: begin
        f_re = 1'b1; f_raddr = f_q;
      end
      mpsm_pkg::OP_BF_SET: begin
        f_we = 1'b1; f_waddr = v_q; f_wdata = g_rdata;
        q_we = tail_room; q_wdata = v_q;
      end
      mpsm_pkg::OP_SC_RD: begin
        g_re = 1'b1; g_raddr = {node_q, sym_q};
      end
      mpsm_pkg::OP_SC_FRD: begin
        f_re = 1'b1; f_raddr = node_q;
      end
      mpsm_pkg::OP_ST_RD: begin
        i_re = 1'b1; i_raddr = t_q; f_re = 1'b1; f_raddr = t_q;
      end
      mpsm_pkg::OP_ST_WRV, mpsm_pkg::OP_ST_STEP: begin
        i_we = 1'b1; i_waddr = t_q; i_wdata = {1'b1, i_cnt, i_dep};
      end
      default: g_we = 1'b0;
    endcase
  end

  // Trie, build and scan registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0; sym_q <= '0; ntot_q <= mpsm_pkg::NCNT_W'(1); head_q <= '0; tail_q <= '0;
      ins_q <= '0; scan_q <= '0; row_q <= '0; u_q <= '0; v_q <= '0; f_q <= '0;
      node_q <= '0; t_q <= '0; ins_dep_q <= '0; pos_q <= '0; built_q <= 1'b0;
      cand_v_q <= 1'b0; cnt_q <= '0; s_q <= '0; nres_q <= '0;
    end else begin
      case (ctrl_i.op)
        mpsm_pkg::OP_LATCH: begin
          cmd_q <= in_data_i[2:0]; sym_q <= in_data_i[3 +: SW]; cand_v_q <= 1'b0;
        end
        mpsm_pkg::OP_CLEAR: begin
          ntot_q <= mpsm_pkg::NCNT_W'(1); ins_q <= '0; ins_dep_q <= '0; scan_q <= '0;
          pos_q <= '0; built_q <= 1'b0; row_q <= '0; cnt_q <= '0;
        end
        mpsm_pkg::OP_SWEEP: cnt_q <= cnt_q + SW'(1);
        mpsm_pkg::OP_ADD_NEW: begin
          ntot_q <= ntot_q + mpsm_pkg::NCNT_W'(1); built_q <= 1'b0; ins_q <= new_node;
          ins_dep_q <= ins_dep_q + DW'(1); row_q <= new_node; cnt_q <= '0;
        end
        mpsm_pkg::OP_ADD_OLD: begin
          ins_q <= g_rdata; ins_dep_q <= ins_dep_q + DW'(1);
        end
        mpsm_pkg::OP_END_WR: begin
          ins_q <= '0; ins_dep_q <= '0;
        end
        mpsm_pkg::OP_START: begin
          scan_q <= '0; pos_q <= '0;
        end
        mpsm_pkg::OP_B_INIT: begin
          s_q <= '0; head_q <= '0; tail_q <= '0;
        end
        mpsm_pkg::OP_B0: begin
          if ((g_rdata != '0) && tail_room) tail_q <= tail_q + mpsm_pkg::NCNT_W'(1);
          s_q <= s_q + SW'(1);
        end
        mpsm_pkg::OP_BQ: begin
          u_q <= q_rdata; head_q <= head_q + mpsm_pkg::NCNT_W'(1); s_q <= '0;
        end
        mpsm_pkg::OP_NEXT_S: s_q <= s_q + SW'(1);
        mpsm_pkg::OP_BU: v_q <= g_rdata;
        mpsm_pkg::OP_BF_LD: f_q <= f_rdata;
        mpsm_pkg::OP_BF_SET: begin
          if (tail_room) tail_q <= tail_q + mpsm_pkg::NCNT_W'(1);
          s_q <= s_q + SW'(1);
        end
        mpsm_pkg::OP_BUILT: built_q <= 1'b1;
        mpsm_pkg::OP_SC_INIT: node_q <= scan_q;
        mpsm_pkg::OP_SC_FW: node_q <= f_rdata;
        mpsm_pkg::OP_SC_SET: begin
          node_q <= g_rdata; scan_q <= g_rdata; t_q <= g_rdata; nres_q <= '0;
        end
        mpsm_pkg::OP_ST_STEP: begin
          if (match) begin
            cand_v_q <= 1'b1; nres_q <= nres_q + mpsm_pkg::NRES_W'(1);
          end
          t_q <= f_rdata;
        end
        mpsm_pkg::OP_PUSH: begin
          nres_q <= nres_q + mpsm_pkg::NRES_W'(1); t_q <= f_rdata;
        end
        default: cmd_q <= cmd_q;
      endcase
      // Text position advances once per built scan, saturating.
      if (ctrl_i.opx == mpsm_pkg::OPX_POS && !(&pos_q)) pos_q <= pos_q + PW'(1);
    end
  end

  // Pending match payload.
  always_ff @(posedge clk_i) begin
    if ((ctrl_i.op == mpsm_pkg::OP_ST_STEP && match) || ctrl_i.op == mpsm_pkg::OP_PUSH) begin
      cand_start_q <= new_start; cand_end_q <= pos_q;
      cand_len_q   <= i_dep;     cand_cnt_q <= i_cnt;
    end
  end

  // Output register: loaded by an intermediate match or a final result.
  assign load_out = (ctrl_i.op == mpsm_pkg::OP_PUSH) || (ctrl_i.opx == mpsm_pkg::OPX_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_last_q <= (ctrl_i.opx == mpsm_pkg::OPX_EMIT);
      if (cand_v_q) begin
        out_st_q <= mpsm_pkg::ST_MATCH; out_start_q <= cand_start_q;
        out_end_q <= cand_end_q; out_len_q <= cand_len_q; out_cnt_q <= cand_cnt_q;
      end else begin
        out_st_q <= ctrl_i.code; out_start_q <= '0; out_end_q <= '0;
        out_len_q <= '0; out_cnt_q <= '0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {7'd0, out_cnt_q, out_len_q, out_end_q, out_start_q, out_st_q};

  // Status towards the controller.
  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.built      = built_q;
    stat_o.depth_full = ins_dep_q >= DW'(mpsm_pkg::MAX_WORD_LEN);
    stat_o.table_full = ntot_q >= mpsm_pkg::NCNT_W'(mpsm_pkg::MAX_NODES);
    stat_o.g_zero     = (g_rdata == '0);
    stat_o.ins_zero   = (ins_q == '0);
    stat_o.sweep_last = &cnt_q;
    stat_o.s_last     = &s_q;
    stat_o.q_more     = head_q < tail_q;
    stat_o.f_zero     = (f_q == '0);
    stat_o.node_zero  = (node_q == '0);
    stat_o.t_zero     = (t_q == '0);
    stat_o.visited    = i_vis;
    stat_o.match      = match;
    stat_o.cand_v     = cand_v_q;
    stat_o.out_full   = out_full;
  end

endmodule

FILE: hw/rtl/multi_pattern_string_matcher_top.sv
// Top level of the Aho-Corasick dictionary matcher.
//
// One input beat on the slave channel carries a command and a symbol: clear,
// add word symbol, end word, build failure links, start text or scan symbol.
// Each command but scan gives one result beat on the master channel; a scan
// gives one beat per newly found word (start, end, length, multiplicity) or a
// single no-match beat, and tlast marks the final beat of each command.
// Commands are taken one at a time. After the result beat is loaded, the
// controller returns to idle and can take the next beat. A scan's work grows
// with the failure links it follows, the output nodes it visits and the words
// it reports. Creating a node clears its goto row. Build walks every symbol
// slot of the root and of each queued node, and follows failure links for each
// edge it finds. After reset, and on clear, row zero of the goto memory is
// swept before the next beat is taken. When the receiver stalls, the output
// register holds its beat; one further input beat may be taken meanwhile, and
// its work halts where it would produce a result until the register frees.
module multi_pattern_string_matcher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // command [2:0], symbol [10:3]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,  // status, match_start, match_end,
                                       // word_length, match_count
  output logic        m_axis_tlast_o
);

  mpsm_pkg::ctrl_t ctrl;
  mpsm_pkg::stat_t stat;

  mpsm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  mpsm_dp u_dp (
    .clk_i, .rst_ni,
    .ctrl_i(ctrl),
    .stat_o(stat),
    .in_data_i(s_axis_tdata_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o(m_axis_tdata_o),
    .out_last_o(m_axis_tlast_o)
  );

endmodule
